[src/phase_sync_laminar_run_detector_assert.svh]
// Assertion macros shared by the laminar run detector modules.
`ifndef PHASE_SYNC_LAMINAR_RUN_DETECTOR_ASSERT_SVH
`define PHASE_SYNC_LAMINAR_RUN_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define PSLRD_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("pslrd assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define PSLRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pslrd assertion failed");
`else
`define PSLRD_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define PSLRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/pslrd_pkg.sv]
// Shared constants and types of the laminar run detector.
`default_nettype none
package pslrd_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int RUN_BITS   = 40;
    localparam int OUT_W      = 40;
    localparam int ROT_W      = 32;
    localparam int DIFF_W     = ROT_W + ANGLE_BITS + 1;
    localparam int CENTER_W   = ANGLE_BITS;
    localparam int HALF_W     = ANGLE_BITS - 1;
    localparam int PERIOD_W   = 16;
    localparam int TRIM_W     = 24;
    localparam int MIN_W      = 32;
    localparam int CUT_W      = TRIM_W + 1;
    localparam int THR_W      = MIN_W + 2;
    localparam int LEN_W      = (RUN_BITS > OUT_W) ? RUN_BITS : OUT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [CENTER_W-1:0] CENTER_RST = CENTER_W'(12517);
    localparam logic [HALF_W-1:0]   HALF_RST   = HALF_W'(12517);
    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(100);
    localparam logic [TRIM_W-1:0]   TRIM_RST   = TRIM_W'(25000);
    localparam logic [MIN_W-1:0]    MIN_RST    = MIN_W'(50000);

    localparam logic signed [ANGLE_BITS:0] HALF_TURN_P = (ANGLE_BITS + 1)'(2 ** (ANGLE_BITS - 1));
    localparam logic signed [ANGLE_BITS:0] HALF_TURN_N = -HALF_TURN_P;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER = 3'd0,
        CFG_HALF   = 3'd1,
        CFG_PERIOD = 3'd2,
        CFG_TRIM   = 3'd3,
        CFG_MIN    = 3'd4
    } t_cfg_idx;

    // One classified sample handed from front end to back end.
    typedef struct packed {
        logic signed [ANGLE_BITS:0] ab_diff;
        logic signed [ROT_W-1:0]    rot;
        logic                       do_check;
        logic                       last;
    } t_item;

    // Live configuration seen by the back end.
    typedef struct packed {
        logic [CENTER_W-1:0] center;
        logic [HALF_W-1:0]   half;
        logic [PERIOD_W-1:0] period;
        logic [CUT_W-1:0]    cut2;
        logic [THR_W-1:0]    thr;
    } t_cfg;

endpackage
`default_nettype wire

[src/phase_sync_laminar_run_detector.sv]
// Top level of the phase synchronization laminar run detector.
`default_nettype none
// Takes one beat per cycle while the queue has room, each carrying two signed
// binary angles (a full turn is 2^16), unwraps both into a saturating 32-bit turn
// difference and, on every check_period-th measuring beat, tests whether the
// absolute unwrapped phase difference falls in sync_center +- sync_half_width
// modulo a full turn. Each passing check lengthens the open run by check_period
// samples; a failing check or a beat with tlast set closes it, and the run minus
// twice trim_length goes out if it exceeds min_length (m_axis_tlast marks the
// flush case). The first beat after reset only seeds the unwrapper. Sustained
// rate is one beat per cycle while the result stream is not held off, set by the
// run count update in the back end; the result beat is registered. A four-entry
// queue sits between the classifying front end and the counting back end, and it
// keeps taking beats while a result waits, until it fills. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
module phase_sync_laminar_run_detector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [pslrd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pslrd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [2*pslrd_pkg::ANGLE_BITS-1:0]   s_axis_tdata,  // angle_a, angle_b
    input  logic                                 s_axis_tuser,  // measure
    input  logic                                 s_axis_tlast,  // last
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [pslrd_pkg::OUT_W-1:0]          m_axis_tdata,  // run_length
    output logic                                 m_axis_tlast   // at_end
);

    localparam int AB = pslrd_pkg::ANGLE_BITS;

    // configuration registers
    logic [pslrd_pkg::CENTER_W-1:0] r_center, n_center;
    logic [pslrd_pkg::HALF_W-1:0]   r_half, n_half;
    logic [pslrd_pkg::PERIOD_W-1:0] r_period, n_period;
    logic [pslrd_pkg::TRIM_W-1:0]   r_trim, n_trim;
    logic [pslrd_pkg::MIN_W-1:0]    r_min, n_min;
    // report threshold 2*trim + min, registered off the compare path
    logic [pslrd_pkg::THR_W-1:0]    r_thr, n_thr;

    pslrd_pkg::t_cfg  w_cfg;
    pslrd_pkg::t_item w_push_item, w_head_item;
    logic             w_push, w_pop, w_full, w_head_valid;

    always_comb begin
        n_center = r_center;
        n_half   = r_half;
        n_period = r_period;
        n_trim   = r_trim;
        n_min    = r_min;
        if (i_cfg_we) begin
            case (pslrd_pkg::t_cfg_idx'(i_cfg_idx))
                pslrd_pkg::CFG_CENTER: n_center = i_cfg_data[pslrd_pkg::CENTER_W-1:0];
                pslrd_pkg::CFG_HALF:   n_half   = i_cfg_data[pslrd_pkg::HALF_W-1:0];
                pslrd_pkg::CFG_PERIOD: n_period = i_cfg_data[pslrd_pkg::PERIOD_W-1:0];
                pslrd_pkg::CFG_TRIM:   n_trim   = i_cfg_data[pslrd_pkg::TRIM_W-1:0];
                pslrd_pkg::CFG_MIN:    n_min    = i_cfg_data[pslrd_pkg::MIN_W-1:0];
                default: ;
            endcase
        end
        n_thr = pslrd_pkg::THR_W'({r_trim, 1'b0}) + pslrd_pkg::THR_W'(r_min);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= pslrd_pkg::CENTER_RST;
            r_half   <= pslrd_pkg::HALF_RST;
            r_period <= pslrd_pkg::PERIOD_RST;
            r_trim   <= pslrd_pkg::TRIM_RST;
            r_min    <= pslrd_pkg::MIN_RST;
            r_thr    <= pslrd_pkg::THR_W'({pslrd_pkg::TRIM_RST, 1'b0})
                      + pslrd_pkg::THR_W'(pslrd_pkg::MIN_RST);
        end else begin
            r_center <= n_center;
            r_half   <= n_half;
            r_period <= n_period;
            r_trim   <= n_trim;
            r_min    <= n_min;
            r_thr    <= n_thr;
        end
    end

    // a zero period behaves as one
    always_comb begin
        w_cfg.center = r_center;
        w_cfg.half   = r_half;
        w_cfg.period = (r_period == '0) ? pslrd_pkg::PERIOD_W'(1) : r_period;
        w_cfg.cut2   = {r_trim, 1'b0};
        w_cfg.thr    = r_thr;
    end

    pslrd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_angle_a (s_axis_tdata[AB-1:0]),
        .i_angle_b (s_axis_tdata[2*AB-1:AB]),
        .i_measure (s_axis_tuser),
        .i_last    (s_axis_tlast),
        .i_period  (w_cfg.period),
        .i_full    (w_full),
        .o_ready   (s_axis_tready),
        .o_push    (w_push),
        .o_item    (w_push_item)
    );

    pslrd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_valid (w_head_valid),
        .o_full  (w_full)
    );

    pslrd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_head_valid),
        .i_item   (w_head_item),
        .i_cfg    (w_cfg),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .i_tready (m_axis_tready)
    );

endmodule
`default_nettype wire

[src/pslrd_front.sv]
// Front end: unwraps both angles, tracks the check phase, classifies each sample.
`default_nettype none
module pslrd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [pslrd_pkg::ANGLE_BITS-1:0] i_angle_a,
    input  logic signed [pslrd_pkg::ANGLE_BITS-1:0] i_angle_b,
    input  logic                                i_measure,
    input  logic                                i_last,
    input  logic [pslrd_pkg::PERIOD_W-1:0]      i_period,
    input  logic                                i_full,
    output logic                                o_ready,
    output logic                                o_push,
    output pslrd_pkg::t_item                    o_item
);

    localparam int AB = pslrd_pkg::ANGLE_BITS;
    localparam int RW = pslrd_pkg::ROT_W;
    localparam int PW = pslrd_pkg::PERIOD_W;

    logic signed [AB-1:0] r_prev_a, n_prev_a;
    logic signed [AB-1:0] r_prev_b, n_prev_b;
    logic                 r_have, n_have;
    logic signed [RW-1:0] r_rot, n_rot;
    logic [PW-1:0]        r_phase, n_phase;

    logic                 w_fire;
    logic signed [AB:0]   w_da, w_db;
    logic signed [1:0]    w_wa, w_wb;
    logic signed [RW+1:0] w_rot_sum;
    logic signed [RW-1:0] w_rot_sat;
    logic [PW:0]          w_ph_inc;
    logic [PW-1:0]        w_ph_next;

    assign o_ready = !i_full;
    assign w_fire  = i_valid && !i_full;
    assign o_push  = w_fire;

    always_comb begin
        w_da = $signed({i_angle_a[AB-1], i_angle_a}) - $signed({r_prev_a[AB-1], r_prev_a});
        w_db = $signed({i_angle_b[AB-1], i_angle_b}) - $signed({r_prev_b[AB-1], r_prev_b});
        // step below minus half a turn: one turn forward; above plus half: one back
        w_wa = (w_da < pslrd_pkg::HALF_TURN_N) ? 2'sd1 :
               (w_da > pslrd_pkg::HALF_TURN_P) ? -2'sd1 : 2'sd0;
        w_wb = (w_db < pslrd_pkg::HALF_TURN_N) ? 2'sd1 :
               (w_db > pslrd_pkg::HALF_TURN_P) ? -2'sd1 : 2'sd0;
        w_rot_sum = $signed({{2{r_rot[RW-1]}}, r_rot})
                  + $signed({{RW{w_wa[1]}}, w_wa})
                  - $signed({{RW{w_wb[1]}}, w_wb});
        // saturate to 32-bit signed
        if (w_rot_sum[RW+1:RW-1] == 3'b000 || w_rot_sum[RW+1:RW-1] == 3'b111) begin
            w_rot_sat = w_rot_sum[RW-1:0];
        end else begin
            w_rot_sat = {w_rot_sum[RW+1], {(RW-1){!w_rot_sum[RW+1]}}};
        end
        w_ph_inc  = {1'b0, r_phase} + (PW + 1)'(1);
        w_ph_next = (w_ph_inc >= {1'b0, i_period}) ? '0 : w_ph_inc[PW-1:0];
    end

    always_comb begin
        o_item.ab_diff  = $signed({i_angle_a[AB-1], i_angle_a})
                        - $signed({i_angle_b[AB-1], i_angle_b});
        o_item.rot      = r_have ? w_rot_sat : r_rot;
        o_item.do_check = r_have && i_measure && (r_phase == '0);
        o_item.last     = i_last;

        n_prev_a = r_prev_a;
        n_prev_b = r_prev_b;
        n_have   = r_have;
        n_rot    = r_rot;
        n_phase  = r_phase;
        if (w_fire) begin
            n_prev_a = i_angle_a;
            n_prev_b = i_angle_b;
            n_have   = 1'b1;
            n_rot    = o_item.rot;
            if (i_last) begin
                n_phase = '0;
            end else if (r_have && i_measure) begin
                n_phase = w_ph_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a <= '0;
            r_prev_b <= '0;
            r_have   <= 1'b0;
            r_rot    <= '0;
            r_phase  <= '0;
        end else begin
            r_prev_a <= n_prev_a;
            r_prev_b <= n_prev_b;
            r_have   <= n_have;
            r_rot    <= n_rot;
            r_phase  <= n_phase;
        end
    end

endmodule
`default_nettype wire

[src/pslrd_fifo.sv]
// Short queue of classified samples between front and back end.
`default_nettype none
`include "phase_sync_laminar_run_detector_assert.svh"
module pslrd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pslrd_pkg::t_item i_item,
    input  logic             i_pop,
    output pslrd_pkg::t_item o_item,
    output logic             o_valid,
    output logic             o_full
);

    localparam int PTW = pslrd_pkg::FIFO_PTR_W;
    localparam int CW  = pslrd_pkg::FIFO_CNT_W;

    pslrd_pkg::t_item r_mem [pslrd_pkg::FIFO_DEPTH];
    logic [PTW-1:0]   r_wr, n_wr;
    logic [PTW-1:0]   r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;

    assign o_item  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(pslrd_pkg::FIFO_DEPTH));

    always_comb begin
        n_wr    = i_push ? r_wr + PTW'(1) : r_wr;
        n_rd    = i_pop  ? r_rd + PTW'(1) : r_rd;
        n_count = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `PSLRD_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(pslrd_pkg::FIFO_DEPTH))
    `PSLRD_ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full))
    `PSLRD_ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, !(i_pop && !o_valid))

endmodule
`default_nettype wire

[src/pslrd_back.sv]
// Back end: band test, run counting and the registered result beat.
`default_nettype none
`include "phase_sync_laminar_run_detector_assert.svh"
module pslrd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  pslrd_pkg::t_item               i_item,
    input  pslrd_pkg::t_cfg                i_cfg,
    output logic                           o_pop,
    output logic                           o_tvalid,
    output logic [pslrd_pkg::OUT_W-1:0]    o_tdata,
    output logic                           o_tlast,
    input  logic                           i_tready
);

    localparam int AB = pslrd_pkg::ANGLE_BITS;
    localparam int DW = pslrd_pkg::DIFF_W;
    localparam int RB = pslrd_pkg::RUN_BITS;
    localparam int LW = pslrd_pkg::LEN_W;
    localparam int OW = pslrd_pkg::OUT_W;

    // band stage
    logic r_a_valid, n_a_valid;
    logic r_a_band, r_a_check, r_a_last;

    logic signed [DW-1:0] w_diff;
    logic [DW-1:0]        w_mag;
    logic signed [AB:0]   w_low;
    logic                 w_below;
    logic [AB-1:0]        w_off;
    logic                 w_band;

    // run stage
    logic [RB-1:0] r_rc, n_rc;
    logic          r_o_valid, n_o_valid;
    logic [OW-1:0] r_o_data;
    logic          r_o_last;

    logic          w_a_load, w_b_fire;
    logic [RB:0]   w_sum;
    logic [RB-1:0] w_sat, w_mid, w_src;
    logic          w_fail, w_emit;
    logic [LW-1:0] w_len;

    assign w_b_fire = r_a_valid && (!r_o_valid || i_tready);
    assign w_a_load = i_valid && (!r_a_valid || w_b_fire);
    assign o_pop    = w_a_load;

    always_comb begin
        w_diff = $signed({i_item.rot[pslrd_pkg::ROT_W-1], i_item.rot, {AB{1'b0}}})
               + $signed({{(DW-AB-1){i_item.ab_diff[AB]}}, i_item.ab_diff});
        w_mag  = w_diff[DW-1] ? DW'(-w_diff) : DW'(w_diff);
        w_low  = $signed({1'b0, i_cfg.center}) - $signed({2'b00, i_cfg.half});
        // a negative lower bound is never above the magnitude
        w_below = !w_low[AB] && (w_mag[DW-1:AB] == '0) && (w_mag[AB-1:0] < w_low[AB-1:0]);
        w_off   = w_mag[AB-1:0] - w_low[AB-1:0];
        w_band  = !w_below && (w_off <= {i_cfg.half, 1'b0});
    end

    always_comb begin
        w_sum  = {1'b0, r_rc} + (RB + 1)'(i_cfg.period);
        w_sat  = w_sum[RB] ? '1 : w_sum[RB-1:0];
        w_fail = r_a_check && !r_a_band;
        w_mid  = r_a_check ? (r_a_band ? w_sat : '0) : r_rc;
        w_src  = w_fail ? r_rc : w_mid;
        w_emit = (w_fail || r_a_last) && (LW'(w_src) > LW'(i_cfg.thr));
        w_len  = LW'(w_src) - LW'(i_cfg.cut2);

        n_a_valid = w_a_load ? 1'b1 : (w_b_fire ? 1'b0 : r_a_valid);
        n_rc      = r_rc;
        n_o_valid = (r_o_valid && !i_tready) ? 1'b1 : 1'b0;
        if (w_b_fire) begin
            n_rc      = r_a_last ? '0 : w_mid;
            n_o_valid = w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_load) begin
            r_a_band  <= w_band;
            r_a_check <= i_item.do_check;
            r_a_last  <= i_item.last;
        end
        if (w_b_fire && w_emit) begin
            r_o_data <= w_len[OW-1:0];
            r_o_last <= !w_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_rc      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_rc      <= n_rc;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_tvalid = r_o_valid;
    assign o_tdata  = r_o_data;
    assign o_tlast  = r_o_last;

    `PSLRD_ASSERT_NEXT(a_flush_clears, i_clk, i_rst_n, w_b_fire && r_a_last, r_rc == '0)
    `PSLRD_ASSERT_NEXT(a_fail_clears, i_clk, i_rst_n, w_b_fire && w_fail, r_rc == '0)

endmodule
`default_nettype wire

[test/tb_phase_sync_laminar_run_detector.sv]
// Self-checking testbench for the phase-sync laminar run detector: directed and random beats.
module tb_phase_sync_laminar_run_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import pslrd_pkg::*;

    // Angle arithmetic in plain integers; a full turn is 2^ANGLE_BITS.
    localparam longint FULL_TURN = longint'(1) << ANGLE_BITS;
    localparam longint HALF_TURN = longint'(1) << (ANGLE_BITS - 1);
    localparam longint RUN_MAX   = (longint'(1) << RUN_BITS) - 1;
    localparam longint ROT_MAX   = 64'sd2147483647;
    localparam longint ROT_MIN   = -64'sd2147483648;
    // Largest per-beat phase move in the drift generator; well under half a turn.
    localparam longint STEP_MAX  = 12000;
    localparam int     LIMIT     = 400000;
    localparam int     HOLD_LEN  = 300;

    typedef struct packed {
        logic [OUT_W-1:0] run_length;
        logic             at_end;
    } t_run_report;

    // Tracks unwrap state and the open run, and queues the run reports due.
    class laminar_run_tracker;
        logic [CENTER_W-1:0] center;
        logic [HALF_W-1:0]   half;
        logic [PERIOD_W-1:0] period;
        logic [TRIM_W-1:0]   trim;
        logic [MIN_W-1:0]    min_len;
        longint              prev_a;
        longint              prev_b;
        bit                  seeded;
        longint              rot;
        longint              phase;
        longint              run_len;
        t_run_report         expected[$];
        int                  mismatches;

        function new();
            center     = CENTER_RST;
            half       = HALF_RST;
            period     = PERIOD_RST;
            trim       = TRIM_RST;
            min_len    = MIN_RST;
            prev_a     = 0;
            prev_b     = 0;
            seeded     = 1'b0;
            rot        = 0;
            phase      = 0;
            run_len    = 0;
            mismatches = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_CENTER: center  = v[CENTER_W-1:0];
                CFG_HALF:   half    = v[HALF_W-1:0];
                CFG_PERIOD: period  = v[PERIOD_W-1:0];
                CFG_TRIM:   trim    = v[TRIM_W-1:0];
                CFG_MIN:    min_len = v[MIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Appends one due report at the tail of the pending list.
        function void queue_report(logic [OUT_W-1:0] len, bit at_end);
            t_run_report r;
            r.run_length = len;
            r.at_end     = at_end;
            expected.insert(expected.size(), r);
        endfunction

        // +1 for a forward wrap, -1 for a backward one; exactly half a turn is no wrap.
        function int turn_step(longint p, longint c);
            longint d;
            d = c - p;
            if (d < -HALF_TURN) return 1;
            if (d > HALF_TURN) return -1;
            return 0;
        endfunction

        // Band is center +- half repeated every full turn, but nothing below the first band.
        function bit band_hit(longint d);
            longint low;
            longint off;
            low = longint'(center) - longint'(half);
            if (d < low) return 1'b0;
            off = (d - low) & (FULL_TURN - 1);
            return off <= 2 * longint'(half);
        endfunction

        function bit closes_report(output logic [OUT_W-1:0] len);
            longint cut;
            cut = 2 * longint'(trim);
            len = '0;
            if (run_len > cut + longint'(min_len)) begin
                len = OUT_W'(run_len - cut);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_sample(logic [ANGLE_BITS-1:0] a_raw, logic [ANGLE_BITS-1:0] b_raw,
                                  bit measure, bit last);
            longint           a;
            longint           b;
            longint           nrot;
            longint           d;
            longint           per;
            logic [OUT_W-1:0] len;
            bit               fired;
            a     = longint'($signed(a_raw));
            b     = longint'($signed(b_raw));
            fired = 1'b0;
            if (seeded) begin
                nrot = rot + turn_step(prev_a, a) - turn_step(prev_b, b);
                if (nrot > ROT_MAX) nrot = ROT_MAX;
                if (nrot < ROT_MIN) nrot = ROT_MIN;
                rot    = nrot;
                prev_a = a;
                prev_b = b;
                if (measure) begin
                    per = (period == 0) ? 1 : longint'(period);
                    if (phase == 0) begin
                        d = (a - b) + rot * FULL_TURN;
                        if (d < 0) d = -d;
                        if (band_hit(d)) begin
                            run_len += per;
                            if (run_len > RUN_MAX) run_len = RUN_MAX;
                        end else begin
                            if (closes_report(len)) begin
                                queue_report(len, 1'b0);
                                fired = 1'b1;
                            end
                            run_len = 0;
                        end
                    end
                    // a phase left beyond a lowered period falls back to zero here
                    phase = (phase + 1 >= per) ? 0 : phase + 1;
                end
            end else begin
                // first beat after reset only seeds the unwrapper
                prev_a = a;
                prev_b = b;
                seeded = 1'b1;
            end
            if (last) begin
                if (!fired && closes_report(len))
                    queue_report(len, 1'b1);
                run_len = 0;
                phase   = 0;
            end
        endfunction

        function void match_report(logic [OUT_W-1:0] len, logic at_end);
            t_run_report want;
            if (expected.size() == 0) begin
                $error("unexpected run report: run_length %0d at_end %0b", len, at_end);
                mismatches++;
                return;
            end
            want = expected.pop_front();
            if (want.run_length !== len) begin
                $error("run_length mismatch: expected %0d, actual %0d", want.run_length, len);
                mismatches++;
            end
            if (want.at_end !== at_end) begin
                $error("at_end mismatch: expected %0b, actual %0b", want.at_end, at_end);
                mismatches++;
            end
        endfunction
    endclass

    // ---------------------------------------------------------------------------------------
    // DUT connections; every input known from time zero
    // ---------------------------------------------------------------------------------------
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [2*ANGLE_BITS-1:0] s_axis_tdata  = '0;  // angle_a, angle_b
    logic                    s_axis_tuser  = 1'b0; // measure
    logic                    s_axis_tlast  = 1'b0; // last
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_W-1:0]        m_axis_tdata;        // run_length
    logic                    m_axis_tlast;        // at_end

    phase_sync_laminar_run_detector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    laminar_run_tracker tracker = new();

    // calm: no idling on either side (last part of the run)
    // hold_req: ask the receiver for one long hold-off
    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int cycles   = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("phase_sync_laminar_run_detector verification failed");
            $finish;
        end
    end

    // Result monitor: every accepted beat is compared with the oldest pending report
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_report(m_axis_tdata, m_axis_tlast);
    end

    // Receiver: random ready/stall bursts, one long hold-off on request, steady when calm
    initial begin
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------------------------

    // One beat; optional idle burst before it. Returns once the beat is accepted.
    task automatic send_beat(logic [ANGLE_BITS-1:0] a, logic [ANGLE_BITS-1:0] b,
                             bit measure, bit last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= measure;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_sample(a, b, measure, last);
    endtask

    // Drain: stop offering, wait for all reports, then let in-flight beats clear the pipe
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (tracker.expected.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // One register write beat; write enable left high for the caller to lower
    task automatic cfg_beat(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        tracker.set_reg(idx, v);
    endtask

    // All five registers; junk above the width of each register but min checks the masking
    task automatic write_config(logic [CENTER_W-1:0] c, logic [HALF_W-1:0] h,
                                logic [PERIOD_W-1:0] p, logic [TRIM_W-1:0] t,
                                logic [MIN_W-1:0] m);
        cfg_beat(CFG_CENTER, {16'($urandom), c});
        cfg_beat(CFG_HALF,   {17'($urandom), h});
        cfg_beat(CFG_PERIOD, {16'($urandom), p});
        cfg_beat(CFG_TRIM,   {8'($urandom), t});
        cfg_beat(CFG_MIN,    m);
        i_cfg_we <= 1'b0;
    endtask

    // Phase-walk generator: steers the unwrapped difference toward a goal inside the band
    // (locked) or half a turn away from it (slipping), a few turns up at random. Both
    // angles move less than half a turn per beat so the unwrap stays faithful.
    task automatic drift(int n, bit locked, int flush_pm, bit close);
        longint goal;
        longint now_d;
        longint step_a;
        longint delta;
        longint a_next;
        longint b_next;
        longint half_l;
        int     k;
        bit     m;
        bit     l;
        half_l = longint'(tracker.half);
        k      = $urandom_range(0, 2);
        if (locked)
            goal = longint'(tracker.center) + FULL_TURN * k
                   + longint'($urandom_range(0, 2 * half_l)) - half_l;
        else
            goal = longint'(tracker.center) + HALF_TURN + FULL_TURN * k;
        if (goal < 0) goal = -goal;
        for (int i = 0; i < n; i++) begin
            now_d = (tracker.prev_a - tracker.prev_b) + FULL_TURN * tracker.rot;
            delta = goal - now_d + longint'($urandom_range(0, 400)) - 200;
            if (delta > STEP_MAX) delta = STEP_MAX;
            if (delta < -STEP_MAX) delta = -STEP_MAX;
            step_a = longint'($urandom_range(0, 2 * STEP_MAX)) - STEP_MAX;
            a_next = tracker.prev_a + step_a;
            b_next = tracker.prev_b + step_a - delta;
            m = ($urandom_range(0, 19) != 0);
            l = (close && i == n - 1) || ($urandom_range(0, 999) < flush_pm);
            send_beat(a_next[ANGLE_BITS-1:0], b_next[ANGLE_BITS-1:0], m, l);
        end
    endtask

    // Mostly locked stretches broken by slips, with some raw noise beats; ends in a flush
    task automatic random_phase(int n, int flush_pm);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_beat(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 15) == 0);
                sent++;
            end else if (r < 75) begin
                len = $urandom_range(5, 80);
                drift(len, 1'b1, flush_pm, 1'b0);
                sent += len;
            end else begin
                len = $urandom_range(1, 6);
                drift(len, 1'b0, flush_pm, 1'b0);
                sent += len;
            end
        end
        drift(1, 1'b1, 0, 1'b1);
    endtask

    // Short periods and small trim/min so runs qualify often; sometimes wide bands
    // or long periods
    task automatic random_setup();
        logic [HALF_W-1:0]   h;
        logic [PERIOD_W-1:0] p;
        h = ($urandom_range(0, 3) == 0) ? HALF_W'($urandom_range(0, 32767))
                                        : HALF_W'($urandom_range(500, 6000));
        p = ($urandom_range(0, 5) == 0) ? PERIOD_W'($urandom_range(7, 300))
                                        : PERIOD_W'($urandom_range(1, 6));
        write_config(CENTER_W'($urandom_range(0, 65535)), h, p,
                     TRIM_W'($urandom_range(0, 10)), MIN_W'($urandom_range(0, 40)));
    endtask

    // ---------------------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings. Seed beat with a flush, then a wraps forward and b backward
        // (rotation difference goes to +2), exact half-turn steps, a settling beat.
        send_beat(16'h7FFF, 16'h8000, 1'b1, 1'b1);
        send_beat(16'h8000, 16'h7FFF, 1'b1, 1'b0);
        send_beat(16'h0000, 16'hFFFF, 1'b1, 1'b0);
        send_beat(16'hFFFF, 16'h0000, 1'b0, 1'b0);
        send_beat(16'h4000, 16'hC000, 1'b1, 1'b1);
        quiesce();

        // Zero-width band at zero, zero period (acts as one), no trim, no minimum.
        // With a == b the difference sits on a band point, so each beat extends the run.
        write_config('0, '0, '0, '0, '0);
        send_beat(16'h0000, 16'h0000, 1'b1, 1'b0);
        send_beat(16'h2000, 16'h2000, 1'b1, 1'b0);
        send_beat(16'h4000, 16'h4000, 1'b1, 1'b0);
        send_beat(16'h6100, 16'h6000, 1'b1, 1'b0);   // off band: run of 3 closes
        send_beat(16'h7000, 16'h7000, 1'b1, 1'b0);
        send_beat(16'h7900, 16'h7800, 1'b1, 1'b1);   // failed check and flush together
        send_beat(16'h7900, 16'h7900, 1'b1, 1'b1);   // flush closes a run of 1
        quiesce();

        // All registers at their maximum
        write_config('1, '1, '1, '1, '1);
        drift(3, 1'b1, 0, 1'b1);
        quiesce();

        // Band reaching below zero, period 6; leaves check phase mid-period
        write_config(16'd100, 15'd5000, 16'd6, '0, '0);
        drift(5, 1'b1, 0, 1'b0);
        quiesce();

        // Period lowered under the current check phase
        write_config(16'd100, 15'd5000, 16'd2, '0, '0);
        drift(4, 1'b1, 0, 1'b1);
        quiesce();

        // Random part
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                // Back-pressure: period 1, half the circle in band, noise beats so reports
                // come every few beats while the receiver sits out a long hold-off.
                write_config(16'd0, 15'd16000, 16'd1, '0, '0);
                hold_req = 1'b1;
                for (int i = 0; i < 80; i++)
                    send_beat(16'($urandom), 16'($urandom), 1'b1, i == 79);
                quiesce();
            end
            random_setup();
            if (ph == 7) calm = 1'b1;
            random_phase(180, 8);
            quiesce();
        end

        if (tracker.mismatches == 0) begin
            $display("phase_sync_laminar_run_detector verification clean");
        end else begin
            $display("phase_sync_laminar_run_detector verification failed");
        end
        $finish;
    end

endmodule

[phase_sync_laminar_run_detector.f]
+incdir+src
src/pslrd_pkg.sv
src/pslrd_front.sv
src/pslrd_fifo.sv
src/pslrd_back.sv
src/phase_sync_laminar_run_detector.sv
test/tb_phase_sync_laminar_run_detector.sv
